### rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants, types and ring pointer helpers for the deque core
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int CAPACITY = 256;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [PTR_W:0]   CAP_EXT  = (PTR_W + 1)'(CAPACITY);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REVERSE    = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic                is_empty;
    logic [DATA_W-1:0]   first_value;
    logic [DATA_W-1:0]   last_value;
  } res_word_t;

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                               input logic [PTR_W-1:0] b);
    logic [PTR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] a);
    return (a == '0) ? PTR_LAST : a - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] a);
    return (a == PTR_LAST) ? '0 : a + 1'b1;
  endfunction

endpackage

### rtl/core/deq_ifs.sv
// ----------------------------------------------------------------------------
// deq_op_if / deq_res_if
// valid/ready channels for operation words and result words
// ----------------------------------------------------------------------------
interface deq_op_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        is_empty;
  logic [31:0] first_value;
  logic [31:0] last_value;

  modport source (output valid, output status, output is_empty,
                  output first_value, output last_value, input ready);
  modport sink   (input valid, input status, input is_empty,
                  input first_value, input last_value, output ready);
endinterface

### rtl/core/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// deque of signed 32-bit words in a ring store with a reversible direction
// an accepted operation passes S_DONE and the output register to give its
// result word; a pop leaving entries behind passes S_FILL first (a store read
// refreshes the cached end value); new operations are taken only in S_IDLE
// reset: synchronous rst empties the queue at once; no clearing pass
// ----------------------------------------------------------------------------
module double_ended_queue_core
  import deq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  deq_op_if.sink   op,
  deq_res_if.source res
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  res_word_t         result;
  logic              slot_free;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_empty;
  logic [DATA_W-1:0]   out_first;
  logic [DATA_W-1:0]   out_last;

  assign slot_free = !out_valid || res.ready;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op.valid),
    .op_ready  (op.ready),
    .op_kind   (op.kind),
    .op_value  (op.value),
    .slot_free (slot_free),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  deq_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && result.valid) begin
      out_status <= result.status;
      out_empty  <= result.is_empty;
      out_first  <= result.first_value;
      out_last   <= result.last_value;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.is_empty    = out_empty;
  assign res.first_value = out_first;
  assign res.last_value  = out_last;

endmodule

### rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module deq_ram
  import deq_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// operation sequencer: ring pointers, cached end values, store refill
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  logic [KIND_W-1:0] op_kind,
  input  logic [DATA_W-1:0] op_value,
  input  logic              slot_free,
  output res_word_t         result,
  output mem_req_t          mem_req,
  input  logic [DATA_W-1:0] mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state;
  logic [PTR_W-1:0]    front;
  logic [OCC_W-1:0]    occ;
  logic                rev;
  logic [DATA_W-1:0]   head_val;
  logic [DATA_W-1:0]   tail_val;
  logic [STATUS_W-1:0] status;
  logic                fill_head;

  logic             accept;
  logic             is_push;
  logic             is_pop;
  logic             full;
  logic             empty;
  logic             push_head;
  logic             pop_head;
  logic [PTR_W-1:0] front_dec;
  logic [PTR_W-1:0] tail_slot;
  logic [PTR_W-1:0] new_tail;
  logic [OCC_W-1:0] occ_m2;

  assign op_ready  = (state == S_IDLE);
  assign accept    = op_valid && op_ready;
  assign is_push   = (op_kind == KIND_PUSH_FRONT) || (op_kind == KIND_PUSH_BACK);
  assign is_pop    = (op_kind == KIND_POP_FRONT) || (op_kind == KIND_POP_BACK);
  assign full      = (occ == OCC_FULL);
  assign empty     = (occ == '0);
  assign push_head = (op_kind == KIND_PUSH_FRONT) ^ rev;
  assign pop_head  = (op_kind == KIND_POP_FRONT) ^ rev;
  assign front_dec = ptr_dec(front);
  assign tail_slot = ptr_add(front, occ[PTR_W-1:0]);
  assign occ_m2    = occ - OCC_W'(2);
  assign new_tail  = ptr_add(front, occ_m2[PTR_W-1:0]);

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = op_value;
    mem_req.waddr = push_head ? front_dec : tail_slot;
    mem_req.raddr = pop_head ? ptr_inc(front) : new_tail;
    if (accept && is_push && !full) begin
      mem_req.we = 1'b1;
    end
    if (accept && is_pop && (occ > OCC_W'(1))) begin
      mem_req.re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      occ   <= '0;
      rev   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_push) begin
              state <= S_DONE;
              if (full) begin
                status <= STATUS_FULL;
              end else begin
                status <= STATUS_OK;
                occ    <= occ + 1'b1;
                if (push_head) begin
                  front <= front_dec;
                end
                if (push_head || empty) begin
                  head_val <= op_value;
                end
                if (!push_head || empty) begin
                  tail_val <= op_value;
                end
              end
            end else if (is_pop) begin
              if (empty) begin
                status <= STATUS_EMPTY;
                state  <= S_DONE;
              end else begin
                status    <= STATUS_OK;
                occ       <= occ - 1'b1;
                fill_head <= pop_head;
                if (pop_head) begin
                  front <= ptr_inc(front);
                end
                state <= (occ > OCC_W'(1)) ? S_FILL : S_DONE;
              end
            end else begin
              status <= STATUS_OK;
              state  <= S_DONE;
              if (op_kind == KIND_REVERSE) begin
                rev <= ~rev;
              end
            end
          end
        end
        S_FILL: begin
          if (fill_head) begin
            head_val <= mem_rdata;
          end else begin
            tail_val <= mem_rdata;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result          = '0;
    result.valid    = (state == S_DONE);
    result.status   = status;
    result.is_empty = empty;
    if (!empty) begin
      result.first_value = rev ? tail_val : head_val;
      result.last_value  = rev ? head_val : tail_val;
    end
  end

endmodule
